// ===== src/line_splitter_filter_defines.svh =====
// Assertion macros used by the top-level file that checks this block.
`ifndef LINE_SPLITTER_FILTER_DEFINES_SVH
`define LINE_SPLITTER_FILTER_DEFINES_SVH

`define LSF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("line splitter check failed");

`define LSF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("line splitter check failed");

`endif

// ===== src/lsf_pkg.sv =====
`timescale 1ns / 1ps
package lsf_pkg;

    localparam int LSF_OFFSET_BITS = 32;
    localparam int LSF_QDEPTH      = 4;

    localparam logic [7:0] LF_BYTE = 8'h0A;
    localparam logic [7:0] CR_BYTE = 8'h0D;

    localparam logic [7:0] MAX_LEN_RESET   = 8'd14;
    localparam logic       PRINTABLE_RESET = 1'b0;

    localparam logic [3:0] REG_MAX_LINE_LEN   = 4'd0;
    localparam logic [3:0] REG_PRINTABLE_ONLY = 4'd1;

    localparam logic [1:0] KIND_KEPT = 2'd0;
    localparam logic [1:0] KIND_JUNK = 2'd1;
    localparam logic [1:0] KIND_END  = 2'd2;

    localparam logic [8:0]  LEN_SAT  = 9'd256;
    localparam logic [31:0] JUNK_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        junk;
        logic [31:0] offset;
        logic [7:0]  length;
        logic        done;
    } t_evt;

    function automatic logic [8:0] sat_inc(input logic [8:0] len);
        logic [8:0] res;
        res = (len == LEN_SAT) ? len : 9'(len + 9'd1);
        return res;
    endfunction

    function automatic logic is_nonprint(input logic [7:0] b);
        logic res;
        res = (b < 8'h20) || (b > 8'h7E);
        return res;
    endfunction

endpackage

// ===== src/lsf_front.sv =====
`timescale 1ns / 1ps
module lsf_front #(
    parameter int OFFSET_BITS = lsf_pkg::LSF_OFFSET_BITS
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_accept,
    input  logic [7:0]   i_data_byte,
    input  logic         i_last_byte,
    input  logic [7:0]   i_max_len,
    input  logic         i_printable,
    output logic         o_evt_valid,
    output lsf_pkg::t_evt o_evt
);
    import lsf_pkg::*;

    logic                   r_open, n_open;
    logic [OFFSET_BITS-1:0] r_pos, n_pos;
    logic [OFFSET_BITS-1:0] r_start, n_start;
    logic [8:0]             r_len, n_len;
    logic                   r_dis, n_dis;
    logic                   r_np, n_np;
    logic                   r_pcr, n_pcr;

    logic [OFFSET_BITS-1:0] start_c;
    logic [8:0]             len_c, len_a, len_b, len_f;
    logic                   dis_c, np_c, pcr_c, np_a, np_b, np_f, pcr_b;
    logic                   close_c, junk_c;

    always_comb begin
        start_c = r_open ? r_start : r_pos;
        len_c   = r_open ? r_len : 9'd0;
        dis_c   = r_open ? r_dis : (i_data_byte == 8'h00);
        np_c    = r_open ? r_np : 1'b0;
        pcr_c   = r_open ? r_pcr : 1'b0;

        len_a = pcr_c ? sat_inc(len_c) : len_c;
        np_a  = np_c | pcr_c;
        if (i_data_byte == CR_BYTE) begin
            pcr_b = 1'b1;
            len_b = len_a;
            np_b  = np_a;
        end else begin
            pcr_b = 1'b0;
            len_b = sat_inc(len_a);
            np_b  = np_a | is_nonprint(i_data_byte);
        end

        if (i_data_byte == LF_BYTE) begin
            close_c = 1'b1;
            len_f   = len_c;
            np_f    = np_c;
        end else begin
            close_c = i_last_byte;
            len_f   = pcr_b ? sat_inc(len_b) : len_b;
            np_f    = np_b | pcr_b;
        end

        junk_c = (len_f == 9'd0) || dis_c || (len_f > {1'b0, i_max_len})
                 || (i_printable && np_f);

        n_open  = r_open;
        n_pos   = r_pos;
        n_start = r_start;
        n_len   = r_len;
        n_dis   = r_dis;
        n_np    = r_np;
        n_pcr   = r_pcr;
        if (i_accept) begin
            n_pos = i_last_byte ? '0 : OFFSET_BITS'(r_pos + 1'b1);
            if (close_c) begin
                n_open = 1'b0;
                n_len  = 9'd0;
                n_dis  = 1'b0;
                n_np   = 1'b0;
                n_pcr  = 1'b0;
            end else begin
                n_open  = 1'b1;
                n_start = start_c;
                n_len   = len_b;
                n_dis   = dis_c;
                n_np    = np_b;
                n_pcr   = pcr_b;
            end
        end

        o_evt_valid  = i_accept && close_c;
        o_evt.junk   = junk_c;
        o_evt.offset = junk_c ? 32'd0 : 32'(start_c);
        o_evt.length = junk_c ? 8'd0 : len_f[7:0];
        o_evt.done   = i_last_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 1'b0;
            r_pos  <= '0;
        end else begin
            r_open <= n_open;
            r_pos  <= n_pos;
        end
        r_start <= n_start;
        r_len   <= n_len;
        r_dis   <= n_dis;
        r_np    <= n_np;
        r_pcr   <= n_pcr;
    end

endmodule

// ===== src/lsf_fifo.sv =====
`timescale 1ns / 1ps
module lsf_fifo #(
    parameter int DEPTH = lsf_pkg::LSF_QDEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr,
    input  lsf_pkg::t_evt i_wdata,
    input  logic          i_rd,
    output lsf_pkg::t_evt o_rdata,
    output logic          o_full,
    output logic          o_empty
);
    import lsf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_evt          r_mem [DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          wr_ok, rd_ok;

    always_comb begin
        o_full  = (r_cnt == CW'(DEPTH));
        o_empty = (r_cnt == '0);
        wr_ok   = i_wr && !o_full;
        rd_ok   = i_rd && !o_empty;
        n_wp    = r_wp;
        n_rp    = r_rp;
        if (wr_ok) begin
            n_wp = (r_wp == PW'(DEPTH - 1)) ? '0 : PW'(r_wp + 1'b1);
        end
        if (rd_ok) begin
            n_rp = (r_rp == PW'(DEPTH - 1)) ? '0 : PW'(r_rp + 1'b1);
        end
        n_cnt = r_cnt;
        if (wr_ok && !rd_ok) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (rd_ok && !wr_ok) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
        o_rdata = r_mem[r_rp];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
        if (wr_ok) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule

// ===== src/lsf_back.sv =====
`timescale 1ns / 1ps
module lsf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_evt_avail,
    input  lsf_pkg::t_evt i_evt,
    output logic          o_evt_take,
    input  logic          i_pop,
    output logic          o_empty,
    output logic [1:0]    o_line_kind,
    output logic [31:0]   o_line_offset,
    output logic [7:0]    o_line_length,
    output logic [31:0]   o_junk_total,
    output logic          o_chunk_done
);
    import lsf_pkg::*;

    logic        r_valid, n_valid;
    logic [31:0] r_junk, n_junk;
    logic [1:0]  r_kind;
    logic [31:0] r_offset;
    logic [7:0]  r_length;
    logic        r_done;

    always_comb begin
        o_evt_take = i_evt_avail && (!r_valid || i_pop);
        n_valid    = r_valid;
        if (o_evt_take) begin
            n_valid = 1'b1;
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
        n_junk = r_junk;
        if (o_evt_take && i_evt.junk && (r_junk != JUNK_MAX)) begin
            n_junk = r_junk + 32'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_junk  <= '0;
        end else begin
            r_valid <= n_valid;
            r_junk  <= n_junk;
        end
        if (o_evt_take) begin
            r_kind   <= i_evt.junk ? KIND_JUNK : KIND_KEPT;
            r_offset <= i_evt.offset;
            r_length <= i_evt.length;
            r_done   <= i_evt.done;
        end
    end

    assign o_empty       = !r_valid;
    assign o_line_kind   = r_kind;
    assign o_line_offset = r_offset;
    assign o_line_length = r_length;
    assign o_junk_total  = r_junk;
    assign o_chunk_done  = r_done;

endmodule

// ===== src/line_splitter_filter.sv =====
`timescale 1ns / 1ps
// A line-ending byte's result is written into the event queue when accepted, then into the output register.
// The front accepts one byte per cycle while the event queue is not full, updating its line state per byte.
// Results drain at one per cycle while pop is held, through a four-entry event queue and an output register.
// Reset is synchronous and active low: it clears line state, position, junk total and queues,
// and sets max_line_len to 14 and printable_only to 0.
`include "line_splitter_filter_defines.svh"
module line_splitter_filter #(
    parameter int OFFSET_BITS = lsf_pkg::LSF_OFFSET_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_line_kind,
    output logic [31:0] o_line_offset,
    output logic [7:0]  o_line_length,
    output logic [31:0] o_junk_total,
    output logic        o_chunk_done,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [3:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    import lsf_pkg::*;

    logic [7:0] r_max_len;
    logic       r_printable;
    logic       accept;
    logic       evt_valid, q_full, q_empty, q_take;
    t_evt       evt_in, evt_out;

    assign o_cfg_ready = 1'b1;
    assign full        = q_full;
    assign accept      = push && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= MAX_LEN_RESET;
            r_printable <= PRINTABLE_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == REG_MAX_LINE_LEN) begin
                r_max_len <= i_cfg_data;
            end else if (i_cfg_index == REG_PRINTABLE_ONLY) begin
                r_printable <= i_cfg_data[0];
            end
        end
    end

    lsf_front #(.OFFSET_BITS(OFFSET_BITS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .i_max_len   (r_max_len),
        .i_printable (r_printable),
        .o_evt_valid (evt_valid),
        .o_evt       (evt_in)
    );

    lsf_fifo #(.DEPTH(LSF_QDEPTH)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (evt_valid),
        .i_wdata (evt_in),
        .i_rd    (q_take),
        .o_rdata (evt_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lsf_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_evt_avail   (!q_empty),
        .i_evt         (evt_out),
        .o_evt_take    (q_take),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_line_kind   (o_line_kind),
        .o_line_offset (o_line_offset),
        .o_line_length (o_line_length),
        .o_junk_total  (o_junk_total),
        .o_chunk_done  (o_chunk_done)
    );

    `LSF_ASSERT_IMP(a_no_end_kind, !empty, o_line_kind != KIND_END)
    `LSF_ASSERT_IMP(a_kept_len, !empty && (o_line_kind == KIND_KEPT), (o_line_length != 8'd0) && (o_line_length <= r_max_len))
    `LSF_ASSERT_IMP(a_junk_zero, !empty && (o_line_kind == KIND_JUNK), (o_line_length == 8'd0) && (o_line_offset == 32'd0))
    `LSF_ASSERT_NXT(a_junk_mono, 1'b1, o_junk_total >= $past(o_junk_total))

endmodule
